@@ hdl/rci_pkg.sv @@
// shared constants, types and saturating arithmetic for the ray / capped cylinder test
`timescale 1ns / 1ps

package rci_pkg;

	localparam int FRAC_BITS = 16;

	typedef logic signed [63:0] fx_t;

	localparam fx_t LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam int EPS_I = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam fx_t EPS = 64'(EPS_I);
	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

	// multiplier: partial products, sum, shift and clamp
	localparam int MUL_LAT = 3;

	// square root of delta scaled by the fraction bits
	localparam int SQ_NW = 62 + FRAC_BITS;
	localparam int SQ_BITS = (63 + FRAC_BITS) / 2;

	// divider: one quotient bit a stage, then sign and clamp
	localparam int DIV_QB = 63 + FRAC_BITS;
	localparam int DIV_LAT = DIV_QB + 1;

	typedef enum logic [2:0] {
		REG_BASE_X,
		REG_BASE_Y,
		REG_BASE_Z,
		REG_AXIS_X,
		REG_AXIS_Y,
		REG_AXIS_Z,
		REG_HEIGHT,
		REG_RADIUS
	} cfg_reg_t;

	function automatic fx_t sat65(input logic signed [64:0] x);
		fx_t r;
		if (x > 65'(LIM)) begin
			r = LIM;
		end else if (x < -65'(LIM)) begin
			r = -LIM;
		end else begin
			r = $signed(x[63:0]);
		end
		return r;
	endfunction

	function automatic fx_t sadd(input fx_t a, input fx_t b);
		return sat65(65'(a) + 65'(b));
	endfunction

	function automatic fx_t dot3(input fx_t p0, input fx_t p1, input fx_t p2);
		return sadd(sadd(p0, p1), p2);
	endfunction

endpackage

@@ hdl/ray_cylinder_intersect.sv @@
// top level: pipelined ray against capped cylinder test, one ray per cycle
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------------
//  ray in   | start, busy      | origin_x/y/z, dir_x/y/z (Q16.16 signed)
//  result   | done (strobe)    | hit, hit_distance (Q15.16 unsigned)
//  config   | cfg_we           | cfg_index, cfg_data
//
//  the longest path is the side path of dot products, a one bit a stage square root
//  and a one bit a stage divider.
//  a new ray is taken every cycle, busy stays low.
//  reset clears the valid bits and loads the default cylinder.
//  each result is shown for one cycle with done high; the receiver cannot stall.
`timescale 1ns / 1ps

module ray_cylinder_intersect (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic               hit,
	output logic [30:0]        hit_distance
);

	localparam int F = rci_pkg::FRAC_BITS;
	localparam int ML = rci_pkg::MUL_LAT;
	localparam int SQB = rci_pkg::SQ_BITS;
	localparam int SQW = rci_pkg::SQ_NW;

	localparam int S_IN = 1;
	localparam int S_AX = S_IN + ML + 1;
	localparam int S_VW = S_AX + ML + 1;
	localparam int S_ABC = S_VW + ML + 1;
	localparam int S_BC = S_ABC + 1;
	localparam int S_DEL = S_BC + ML + 1;
	localparam int S_SQ = S_DEL + SQB;
	localparam int S_NUM = S_SQ + 1;
	localparam int S_T = S_NUM + rci_pkg::DIV_LAT;
	localparam int S_Q = S_T + ML + 1;
	localparam int S_PJ = S_Q + ML + 1;
	localparam int S_SH = S_PJ + 1;
	localparam int S_OUT = S_SH + 1;
	localparam int S_CT = S_AX + rci_pkg::DIV_LAT;
	localparam int S_CQ = S_CT + ML + 1;
	localparam int S_CR = S_CQ + ML + 1;
	localparam int S_CH = S_CR + 1;

	localparam int M_PBU = 0;
	localparam int M_DU = 3;
	localparam int M_WTU = 6;
	localparam int M_V = 9;
	localparam int M_W = 12;
	localparam int M_WW = 15;
	localparam int M_VW = 18;
	localparam int M_VV = 21;
	localparam int M_AC = 24;
	localparam int M_BB = 25;
	localparam int M_SQ0 = 26;
	localparam int M_SQ1 = 29;
	localparam int M_PJ0 = 32;
	localparam int M_PJ1 = 35;
	localparam int M_CB = 38;
	localparam int M_CT = 41;
	localparam int M_RB = 44;
	localparam int M_RT = 47;
	localparam int NM = 50;

	// configuration
	logic signed [31:0] base_q [3];
	logic signed [17:0] axis_q [3];
	logic [30:0]        height_q;
	logic [30:0]        radius_q;
	logic [61:0]        r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= '0;
			base_q[1] <= '0;
			base_q[2] <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= 18'sd65536;
			axis_q[2] <= '0;
			height_q <= 31'd65536;
			radius_q <= 31'd65536;
		end else if (cfg_we) begin
			unique case (rci_pkg::cfg_reg_t'(cfg_index))
				rci_pkg::REG_BASE_X: base_q[0] <= $signed(cfg_data);
				rci_pkg::REG_BASE_Y: base_q[1] <= $signed(cfg_data);
				rci_pkg::REG_BASE_Z: base_q[2] <= $signed(cfg_data);
				rci_pkg::REG_AXIS_X: axis_q[0] <= $signed(cfg_data[17:0]);
				rci_pkg::REG_AXIS_Y: axis_q[1] <= $signed(cfg_data[17:0]);
				rci_pkg::REG_AXIS_Z: axis_q[2] <= $signed(cfg_data[17:0]);
				rci_pkg::REG_HEIGHT: height_q <= cfg_data[30:0];
				rci_pkg::REG_RADIUS: radius_q <= cfg_data[30:0];
			endcase
		end
	end

	logic [61:0] rad_sq;
	assign rad_sq = 62'(radius_q) * 62'(radius_q);

	always_ff @(posedge clk) begin
		r2_q <= rad_sq >> F;
	end

	// top cap offset along the axis
	logic signed [49:0] axh [3];
	logic signed [31:0] o_in [3];
	logic signed [31:0] d_in [3];

	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	for (genvar i = 0; i < 3; i++) begin : g_axh
		assign axh[i] = axis_q[i] * $signed({1'b0, height_q});
	end

	// valid line
	logic valid_s [S_IN:S_OUT];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = S_IN; k <= S_OUT; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s[S_IN] <= start && !busy;
			for (int k = S_IN + 1; k <= S_OUT; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// multipliers
	rci_pkg::fx_t ma [NM];
	rci_pkg::fx_t mb [NM];
	rci_pkg::fx_t mp [NM];

	for (genvar m = 0; m < NM; m++) begin : g_mul
		rci_mul u_mul (
			.clk (clk),
			.a   (ma[m]),
			.b   (mb[m]),
			.p   (mp[m])
		);
	end

	// pipeline registers
	logic signed [32:0] pb_s [S_IN:S_T+ML][3];
	logic signed [31:0] d_s  [S_IN:S_T][3];
	logic signed [33:0] wt_s [S_IN:S_CT+ML][3];

	rci_pkg::fx_t pbu_s5, du_s5, wtu_s5;
	rci_pkg::fx_t v_s9 [3];
	rci_pkg::fx_t w_s9 [3];
	rci_pkg::fx_t bdot_s13, vv_s13;
	rci_pkg::fx_t a_s [S_ABC:S_SQ];
	rci_pkg::fx_t b_s [S_BC:S_SQ];
	rci_pkg::fx_t c_s14;
	rci_pkg::fx_t delta_s18;
	logic sen_s [S_DEL:S_SH-1];
	logic capen_s [S_AX:S_CH-1];

	logic [SQW-1:0] sq_rem_s [1:SQB];
	logic [SQB-1:0] sq_res_s [1:SQB];

	rci_pkg::fx_t num0_s, num1_s, den_s;
	rci_pkg::fx_t side_t0, side_t1, cap_tb, cap_tt;
	rci_pkg::fx_t t0_s [S_T+1:S_SH];
	rci_pkg::fx_t t1_s [S_T+1:S_SH];
	rci_pkg::fx_t q0_s [3];
	rci_pkg::fx_t q1_s [3];
	rci_pkg::fx_t pj0_s, pj1_s;
	logic sh0_s, sh1_s;

	rci_pkg::fx_t ctb_s [S_CT+1:S_SH];
	rci_pkg::fx_t ctt_s [S_CT+1:S_SH];
	rci_pkg::fx_t qb_s [3];
	rci_pkg::fx_t qt_s [3];
	rci_pkg::fx_t rrb_s, rrt_s;
	logic chb_s [S_CH:S_SH];
	logic cht_s [S_CH:S_SH];

	// multiplier operand routing
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ma[M_PBU+i] = 64'(pb_s[S_IN][i]);
			mb[M_PBU+i] = 64'(axis_q[i]);
			ma[M_DU+i]  = 64'(d_s[S_IN][i]);
			mb[M_DU+i]  = 64'(axis_q[i]);
			ma[M_WTU+i] = 64'(wt_s[S_IN][i]);
			mb[M_WTU+i] = 64'(axis_q[i]);
			ma[M_V+i]   = 64'(axis_q[i]);
			mb[M_V+i]   = pbu_s5;
			ma[M_W+i]   = 64'(axis_q[i]);
			mb[M_W+i]   = du_s5;
			ma[M_WW+i]  = w_s9[i];
			mb[M_WW+i]  = w_s9[i];
			ma[M_VW+i]  = v_s9[i];
			mb[M_VW+i]  = w_s9[i];
			ma[M_VV+i]  = v_s9[i];
			mb[M_VV+i]  = v_s9[i];
			ma[M_SQ0+i] = side_t0;
			mb[M_SQ0+i] = 64'(d_s[S_T][i]);
			ma[M_SQ1+i] = side_t1;
			mb[M_SQ1+i] = 64'(d_s[S_T][i]);
			ma[M_PJ0+i] = q0_s[i];
			mb[M_PJ0+i] = 64'(axis_q[i]);
			ma[M_PJ1+i] = q1_s[i];
			mb[M_PJ1+i] = 64'(axis_q[i]);
			ma[M_CB+i]  = cap_tb;
			mb[M_CB+i]  = 64'(d_s[S_CT][i]);
			ma[M_CT+i]  = cap_tt;
			mb[M_CT+i]  = 64'(d_s[S_CT][i]);
			ma[M_RB+i]  = qb_s[i];
			mb[M_RB+i]  = qb_s[i];
			ma[M_RT+i]  = qt_s[i];
			mb[M_RT+i]  = qt_s[i];
		end
		ma[M_AC] = a_s[S_BC];
		mb[M_AC] = c_s14;
		ma[M_BB] = b_s[S_BC];
		mb[M_BB] = b_s[S_BC];
	end

	// discriminant
	rci_pkg::fx_t ac2, ac4, delta;
	rci_pkg::fx_t du_sum;

	assign ac2 = rci_pkg::sadd(mp[M_AC], mp[M_AC]);
	assign ac4 = rci_pkg::sadd(ac2, ac2);
	assign delta = rci_pkg::sadd(mp[M_BB], -ac4);
	assign du_sum = rci_pkg::dot3(mp[M_DU], mp[M_DU+1], mp[M_DU+2]);

	// square root, one result bit a stage
	logic [SQW-1:0] sq_n0;
	assign sq_n0 = delta_s18[63] ? '0 : {delta_s18[61:0], {F{1'b0}}};

	for (genvar j = 1; j <= SQB; j++) begin : g_sq
		localparam int I = SQB - j;
		logic [SQW-1:0] rp;
		logic [SQB-1:0] sp;
		logic [SQW+1:0] tr;
		if (j == 1) begin : g_first
			assign rp = sq_n0;
			assign sp = '0;
		end else begin : g_next
			assign rp = sq_rem_s[j-1];
			assign sp = sq_res_s[j-1];
		end
		assign tr = ((SQW+2)'(sp) << (I + 1)) + ((SQW+2)'(1) << (2 * I));
		always_ff @(posedge clk) begin
			if ({2'b00, rp} >= tr) begin
				sq_rem_s[j] <= SQW'({2'b00, rp} - tr);
				sq_res_s[j] <= sp | (SQB'(1) << I);
			end else begin
				sq_rem_s[j] <= rp;
				sq_res_s[j] <= sp;
			end
		end
	end

	// dividers
	rci_div u_div_s0 (.clk(clk), .num(num0_s), .den(den_s), .quo(side_t0));
	rci_div u_div_s1 (.clk(clk), .num(num1_s), .den(den_s), .quo(side_t1));
	rci_div u_div_cb (.clk(clk), .num(-pbu_s5), .den(du_s5), .quo(cap_tb));
	rci_div u_div_ct (.clk(clk), .num(-wtu_s5), .den(du_s5), .quo(cap_tt));

	rci_pkg::fx_t root;
	assign root = 64'(sq_res_s[SQB]);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pb_s[S_IN][i] <= 33'(o_in[i]) - 33'(base_q[i]);
			d_s[S_IN][i] <= d_in[i];
			wt_s[S_IN][i] <= 34'(o_in[i]) - 34'(base_q[i]) - 34'(axh[i] >>> F);
			for (int k = S_IN + 1; k <= S_T + ML; k++) begin
				pb_s[k][i] <= pb_s[k-1][i];
			end
			for (int k = S_IN + 1; k <= S_T; k++) begin
				d_s[k][i] <= d_s[k-1][i];
			end
			for (int k = S_IN + 1; k <= S_CT + ML; k++) begin
				wt_s[k][i] <= wt_s[k-1][i];
			end
			v_s9[i] <= rci_pkg::sadd(64'(pb_s[S_VW-1][i]), -mp[M_V+i]);
			w_s9[i] <= rci_pkg::sadd(64'(d_s[S_VW-1][i]), -mp[M_W+i]);
			q0_s[i] <= rci_pkg::sadd(64'(pb_s[S_Q-1][i]), mp[M_SQ0+i]);
			q1_s[i] <= rci_pkg::sadd(64'(pb_s[S_Q-1][i]), mp[M_SQ1+i]);
			qb_s[i] <= rci_pkg::sadd(64'(pb_s[S_CQ-1][i]), mp[M_CB+i]);
			qt_s[i] <= rci_pkg::sadd(64'(wt_s[S_CQ-1][i]), mp[M_CT+i]);
		end

		pbu_s5 <= rci_pkg::dot3(mp[M_PBU], mp[M_PBU+1], mp[M_PBU+2]);
		du_s5 <= du_sum;
		wtu_s5 <= rci_pkg::dot3(mp[M_WTU], mp[M_WTU+1], mp[M_WTU+2]);
		capen_s[S_AX] <= du_sum != '0;
		for (int k = S_AX + 1; k <= S_CH - 1; k++) begin
			capen_s[k] <= capen_s[k-1];
		end

		a_s[S_ABC] <= rci_pkg::dot3(mp[M_WW], mp[M_WW+1], mp[M_WW+2]);
		bdot_s13 <= rci_pkg::dot3(mp[M_VW], mp[M_VW+1], mp[M_VW+2]);
		vv_s13 <= rci_pkg::dot3(mp[M_VV], mp[M_VV+1], mp[M_VV+2]);
		for (int k = S_ABC + 1; k <= S_SQ; k++) begin
			a_s[k] <= a_s[k-1];
		end

		b_s[S_BC] <= rci_pkg::sadd(bdot_s13, bdot_s13);
		c_s14 <= rci_pkg::sadd(vv_s13, -$signed({2'b00, r2_q}));
		for (int k = S_BC + 1; k <= S_SQ; k++) begin
			b_s[k] <= b_s[k-1];
		end

		delta_s18 <= delta;
		sen_s[S_DEL] <= (a_s[S_DEL-1] > 0) && !delta[63];
		for (int k = S_DEL + 1; k <= S_SH - 1; k++) begin
			sen_s[k] <= sen_s[k-1];
		end

		num0_s <= rci_pkg::sadd(-b_s[S_SQ], -root);
		num1_s <= rci_pkg::sadd(-b_s[S_SQ], root);
		den_s <= rci_pkg::sadd(a_s[S_SQ], a_s[S_SQ]);

		t0_s[S_T+1] <= side_t0;
		t1_s[S_T+1] <= side_t1;
		for (int k = S_T + 2; k <= S_SH; k++) begin
			t0_s[k] <= t0_s[k-1];
			t1_s[k] <= t1_s[k-1];
		end
		pj0_s <= rci_pkg::dot3(mp[M_PJ0], mp[M_PJ0+1], mp[M_PJ0+2]);
		pj1_s <= rci_pkg::dot3(mp[M_PJ1], mp[M_PJ1+1], mp[M_PJ1+2]);
		sh0_s <= sen_s[S_SH-1] && (t0_s[S_SH-1] > rci_pkg::EPS) && !pj0_s[63]
			&& (pj0_s <= $signed({33'd0, height_q}));
		sh1_s <= sen_s[S_SH-1] && (t1_s[S_SH-1] > rci_pkg::EPS) && !pj1_s[63]
			&& (pj1_s <= $signed({33'd0, height_q}));

		ctb_s[S_CT+1] <= cap_tb;
		ctt_s[S_CT+1] <= cap_tt;
		for (int k = S_CT + 2; k <= S_SH; k++) begin
			ctb_s[k] <= ctb_s[k-1];
			ctt_s[k] <= ctt_s[k-1];
		end
		rrb_s <= rci_pkg::dot3(mp[M_RB], mp[M_RB+1], mp[M_RB+2]);
		rrt_s <= rci_pkg::dot3(mp[M_RT], mp[M_RT+1], mp[M_RT+2]);
		chb_s[S_CH] <= capen_s[S_CH-1] && (ctb_s[S_CH-1] > rci_pkg::EPS)
			&& (rrb_s <= $signed({2'b00, r2_q}));
		cht_s[S_CH] <= capen_s[S_CH-1] && (ctt_s[S_CH-1] > rci_pkg::EPS)
			&& (rrt_s <= $signed({2'b00, r2_q}));
		for (int k = S_CH + 1; k <= S_SH; k++) begin
			chb_s[k] <= chb_s[k-1];
			cht_s[k] <= cht_s[k-1];
		end
	end

	// nearest hit
	rci_pkg::fx_t c0, c1, c2, c3, m01, m23, best;
	logic hit_any;
	logic [30:0] near_dist;

	always_comb begin
		c0 = sh0_s ? t0_s[S_SH] : rci_pkg::LIM;
		c1 = sh1_s ? t1_s[S_SH] : rci_pkg::LIM;
		c2 = chb_s[S_SH] ? ctb_s[S_SH] : rci_pkg::LIM;
		c3 = cht_s[S_SH] ? ctt_s[S_SH] : rci_pkg::LIM;
		m01 = (c0 < c1) ? c0 : c1;
		m23 = (c2 < c3) ? c2 : c3;
		best = (m01 < m23) ? m01 : m23;
		hit_any = sh0_s || sh1_s || chb_s[S_SH] || cht_s[S_SH];
		if (hit_any && (best < 64'(rci_pkg::DIST_MAX))) begin
			near_dist = best[30:0];
		end else begin
			near_dist = rci_pkg::DIST_MAX;
		end
	end

	logic        out_hit_q;
	logic [30:0] out_dist_q;

	always_ff @(posedge clk) begin
		if (valid_s[S_SH]) begin
			out_hit_q <= hit_any;
			out_dist_q <= near_dist;
		end
	end

	assign done = valid_s[S_OUT];
	assign hit = out_hit_q;
	assign hit_distance = out_dist_q;

	// every accepted item comes out with done high after passing the whole pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##S_OUT done)
		else $error("item did not come out after the pipeline latency");

	// a hit always lies beyond epsilon
	a_hit_eps: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> hit_distance > 31'(rci_pkg::EPS_I))
		else $error("hit reported at or below epsilon");

endmodule

@@ hdl/rci_mul.sv @@
// pipelined fixed point multiplier: floor(a*b / 2^frac) clamped, built from 33x33 products
`timescale 1ns / 1ps

module rci_mul (
	input  logic         clk,
	input  rci_pkg::fx_t a,
	input  rci_pkg::fx_t b,
	output rci_pkg::fx_t p
);

	localparam logic signed [129:0] LIM_W = 130'(rci_pkg::LIM);

	logic signed [32:0] al, ah, bl, bh;
	logic signed [65:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic signed [129:0] sum;
	logic signed [129:0] full_s2;
	logic signed [129:0] shr;

	assign al = $signed({1'b0, a[31:0]});
	assign ah = $signed({a[63], a[63:32]});
	assign bl = $signed({1'b0, b[31:0]});
	assign bh = $signed({b[63], b[63:32]});

	always_ff @(posedge clk) begin
		ll_s1 <= al * bl;
		lh_s1 <= al * bh;
		hl_s1 <= ah * bl;
		hh_s1 <= ah * bh;
	end

	always_comb begin
		sum = 130'(ll_s1) + (130'(lh_s1) <<< 32) + (130'(hl_s1) <<< 32) + (130'(hh_s1) <<< 64);
	end

	always_ff @(posedge clk) begin
		full_s2 <= sum;
	end

	assign shr = full_s2 >>> rci_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		if (shr > LIM_W) begin
			p <= rci_pkg::LIM;
		end else if (shr < -LIM_W) begin
			p <= -rci_pkg::LIM;
		end else begin
			p <= $signed(shr[63:0]);
		end
	end

endmodule

@@ hdl/rci_div.sv @@
// pipelined restoring divider: num * 2^frac / den truncated toward zero, clamped, zero when den is zero
`timescale 1ns / 1ps

module rci_div (
	input  logic         clk,
	input  rci_pkg::fx_t num,
	input  rci_pkg::fx_t den,
	output rci_pkg::fx_t quo
);

	localparam int QB = rci_pkg::DIV_QB;

	logic [62:0] un, ud_in;
	logic neg_in;
	logic [QB-1:0] n0;

	logic [62:0]   rem_s [1:QB];
	logic [QB-1:0] n_s   [1:QB];
	logic [QB-1:0] q_s   [1:QB];
	logic [62:0]   ud_s  [1:QB];
	logic          neg_s [1:QB];

	assign un = num[63] ? 63'(-num) : num[62:0];
	assign ud_in = den[63] ? 63'(-den) : den[62:0];
	assign neg_in = num[63] ^ den[63];
	assign n0 = {un, {rci_pkg::FRAC_BITS{1'b0}}};

	for (genvar j = 1; j <= QB; j++) begin : g_it
		logic [62:0]   rp, dp;
		logic [QB-1:0] np, qp;
		logic          ngp;
		logic [63:0]   tr;
		if (j == 1) begin : g_first
			assign rp = '0;
			assign np = n0;
			assign qp = '0;
			assign dp = ud_in;
			assign ngp = neg_in;
		end else begin : g_next
			assign rp = rem_s[j-1];
			assign np = n_s[j-1];
			assign qp = q_s[j-1];
			assign dp = ud_s[j-1];
			assign ngp = neg_s[j-1];
		end
		assign tr = {rp, np[QB-1]};
		always_ff @(posedge clk) begin
			if (tr >= {1'b0, dp}) begin
				rem_s[j] <= 63'(tr - {1'b0, dp});
				q_s[j] <= {qp[QB-2:0], 1'b1};
			end else begin
				rem_s[j] <= tr[62:0];
				q_s[j] <= {qp[QB-2:0], 1'b0};
			end
			n_s[j] <= {np[QB-2:0], 1'b0};
			ud_s[j] <= dp;
			neg_s[j] <= ngp;
		end
	end

	rci_pkg::fx_t mq;

	always_comb begin
		if (|q_s[QB][QB-1:62]) begin
			mq = rci_pkg::LIM;
		end else begin
			mq = $signed({2'b00, q_s[QB][61:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (ud_s[QB] == '0) begin
			quo <= '0;
		end else if (neg_s[QB]) begin
			quo <= -mq;
		end else begin
			quo <= mq;
		end
	end

endmodule
